FILE: hdl/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// Types and codes shared by the nearest-neighbour tour unit.
// ----------------------------------------------------------------------------
package nnt_pkg;

    // Widths of the city count and of the request and result fields
    localparam int COUNT_W = 7;
    localparam int CITY_W  = 6;
    localparam int FIELD_W = 16;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_BUILD = 1'b1;

    // Request item
    typedef struct packed {
        logic                      req_type;
        logic [CITY_W-1:0]         city_index;
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
        logic [CITY_W-1:0]         start_city;
    } nnt_req_t;

    // Result item
    typedef struct packed {
        logic [CITY_W-1:0] tour_city;
        logic              last_of_tour;
    } nnt_res_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_LD_CUR,
        ST_SCAN,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_EMIT
    } nnt_state_t;

    // Controls from the sequencer to the distance unit
    typedef struct packed {
        logic load_cur;
        logic diff_en;
        logic sqx_en;
        logic sqy_en;
        logic cmp_en;
        logic first;
    } nnt_dist_ctl_t;

endpackage

FILE: hdl/nnt_point_store.sv
// ----------------------------------------------------------------------------
// nnt_point_store
// Coordinate memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nnt_point_store #(
    parameter int MAX_CITIES  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [$clog2(MAX_CITIES)-1:0]         waddr,
    input  logic signed [nnt_pkg::FIELD_W-1:0]    wx,
    input  logic signed [nnt_pkg::FIELD_W-1:0]    wy,
    input  logic [$clog2(MAX_CITIES)-1:0]         raddr,
    output logic signed [COORD_WIDTH-1:0]         rx,
    output logic signed [COORD_WIDTH-1:0]         ry
);
    import nnt_pkg::*;

    logic signed [COORD_WIDTH-1:0] x_mem [MAX_CITIES];
    logic signed [COORD_WIDTH-1:0] y_mem [MAX_CITIES];
    logic signed [COORD_WIDTH-1:0] wx_ext;
    logic signed [COORD_WIDTH-1:0] wy_ext;

    // Fit the input fields to the stored coordinate width
    generate
        if (COORD_WIDTH <= FIELD_W) begin : g_trunc
            assign wx_ext = wx[COORD_WIDTH-1:0];
            assign wy_ext = wy[COORD_WIDTH-1:0];
        end else begin : g_sext
            assign wx_ext = {{(COORD_WIDTH-FIELD_W){wx[FIELD_W-1]}}, wx};
            assign wy_ext = {{(COORD_WIDTH-FIELD_W){wy[FIELD_W-1]}}, wy};
        end
    endgenerate

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            x_mem[waddr] <= wx_ext;
            y_mem[waddr] <= wy_ext;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rx <= x_mem[raddr];
        ry <= y_mem[raddr];
    end

endmodule

FILE: hdl/nnt_dist_unit.sv
// ----------------------------------------------------------------------------
// nnt_dist_unit
// Squared distance with one shared multiplier, and running minimum compare.
// ----------------------------------------------------------------------------
module nnt_dist_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  nnt_pkg::nnt_dist_ctl_t        ctl,
    input  logic signed [COORD_WIDTH-1:0] rx,
    input  logic signed [COORD_WIDTH-1:0] ry,
    output logic                          better
);
    import nnt_pkg::*;

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int SUM_W = SQ_W + 1;

    logic signed [COORD_WIDTH-1:0] cx_reg;
    logic signed [COORD_WIDTH-1:0] cy_reg;
    logic [COORD_WIDTH-1:0]        dx_reg, dx_next;
    logic [COORD_WIDTH-1:0]        dy_reg, dy_next;
    logic [SQ_W-1:0]               sx_reg;
    logic [SQ_W-1:0]               sy_reg;
    logic [SUM_W-1:0]              best_reg;
    logic [SUM_W-1:0]              sum;
    logic [COORD_WIDTH-1:0]        mul_op;
    logic [SQ_W-1:0]               prod;
    logic signed [COORD_WIDTH:0]   ddx, ddy;
    logic [COORD_WIDTH:0]          ndx, ndy;

    // Absolute coordinate differences to the current city
    always_comb
    begin
        ddx = {rx[COORD_WIDTH-1], rx} - {cx_reg[COORD_WIDTH-1], cx_reg};
        ddy = {ry[COORD_WIDTH-1], ry} - {cy_reg[COORD_WIDTH-1], cy_reg};
        ndx = -ddx;
        ndy = -ddy;
        dx_next = ddx[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : ddx[COORD_WIDTH-1:0];
        dy_next = ddy[COORD_WIDTH] ? ndy[COORD_WIDTH-1:0] : ddy[COORD_WIDTH-1:0];
    end

    // Shared squaring multiplier
    assign mul_op = ctl.sqx_en ? dx_reg : dy_reg;
    assign prod   = SQ_W'(mul_op * mul_op);

    // Sum and compare against the best so far
    assign sum    = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign better = ctl.first || (sum < best_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load_cur)
        begin
            cx_reg <= rx;
            cy_reg <= ry;
        end
        if (ctl.diff_en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (ctl.sqx_en)
        begin
            sx_reg <= prod;
        end
        if (ctl.sqy_en)
        begin
            sy_reg <= prod;
        end
        if (ctl.cmp_en && better)
        begin
            best_reg <= sum;
        end
    end

endmodule

FILE: hdl/nnt_ctrl.sv
// ----------------------------------------------------------------------------
// nnt_ctrl
// Tour sequencer: request handling, visited marks, scan and result register.
// ----------------------------------------------------------------------------
module nnt_ctrl #(
    parameter int MAX_CITIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  nnt_pkg::nnt_req_t                 req,
    output logic                              res_valid,
    input  logic                              res_ready,
    output nnt_pkg::nnt_res_t                 res,
    input  logic                              cfg_we,
    input  logic [nnt_pkg::COUNT_W-1:0]       cfg_data,
    output logic                              store_we,
    output logic [$clog2(MAX_CITIES)-1:0]     store_waddr,
    output logic [$clog2(MAX_CITIES)-1:0]     store_raddr,
    output nnt_pkg::nnt_dist_ctl_t            dctl,
    input  logic                              better
);
    import nnt_pkg::*;

    localparam int IDX_W = $clog2(MAX_CITIES);
    localparam int CNT_W = $clog2(MAX_CITIES + 1);

    nnt_state_t              state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [MAX_CITIES-1:0]   visited_reg, visited_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic [CNT_W-1:0]        emitted_reg, emitted_next;
    logic                    found_reg, found_next;
    logic                    res_valid_reg, res_valid_next;
    nnt_res_t                res_reg, res_next;
    logic [COUNT_W-1:0]      n_eff7;
    logic [CNT_W-1:0]        n_eff;
    logic                    accept;
    logic                    last;
    logic [IDX_W-1:0]        scan_idx;

    // Effective city count
    always_comb
    begin
        if (count_reg == '0)
            n_eff7 = COUNT_W'(1);
        else if (count_reg > COUNT_W'(MAX_CITIES))
            n_eff7 = COUNT_W'(MAX_CITIES);
        else
            n_eff7 = count_reg;
    end
    assign n_eff = n_eff7[CNT_W-1:0];

    assign req_ready   = (state_reg == ST_IDLE);
    assign accept      = req_valid && req_ready;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;
    assign scan_idx    = scan_reg[IDX_W-1:0];
    assign last        = (CNT_W'(emitted_reg + 1'b1) == n_eff);

    // Store ports
    assign store_we    = accept && (req.req_type == REQ_LOAD) &&
                         (COUNT_W'(req.city_index) < COUNT_W'(MAX_CITIES));
    assign store_waddr = req.city_index[IDX_W-1:0];
    assign store_raddr = (state_reg == ST_RD_CUR) ? cur_reg : scan_idx;

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        visited_next   = visited_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        scan_next      = scan_reg;
        emitted_next   = emitted_reg;
        found_next     = found_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        dctl           = '0;
        dctl.first     = !found_reg;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_BUILD) &&
                    (COUNT_W'(req.start_city) < n_eff7))
                begin
                    visited_next = '0;
                    best_next    = req.start_city[IDX_W-1:0];
                    emitted_next = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_RD_CUR:
            begin
                state_next = ST_LD_CUR;
            end
            ST_LD_CUR:
            begin
                dctl.load_cur = 1'b1;
                scan_next     = '0;
                found_next    = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_reg >= n_eff)
                    state_next = ST_EMIT;
                else if (visited_reg[scan_idx])
                    scan_next = scan_reg + 1'b1;
                else
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dctl.diff_en = 1'b1;
                state_next   = ST_SQX;
            end
            ST_SQX:
            begin
                dctl.sqx_en = 1'b1;
                state_next  = ST_SQY;
            end
            ST_SQY:
            begin
                dctl.sqy_en = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                dctl.cmp_en = 1'b1;
                if (better)
                begin
                    best_next  = scan_idx;
                    found_next = 1'b1;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = ST_SCAN;
            end
            ST_EMIT:
            begin
                // Wait for a free result register
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next         = 1'b1;
                    res_next.tour_city     = CITY_W'(best_reg);
                    res_next.last_of_tour  = last;
                    visited_next[best_reg] = 1'b1;
                    cur_next               = best_reg;
                    emitted_next           = emitted_reg + 1'b1;
                    state_next             = last ? ST_IDLE : ST_RD_CUR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_W'(64);
            visited_reg   <= '0;
            cur_reg       <= '0;
            emitted_reg   <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            cur_reg       <= cur_next;
            emitted_reg   <= emitted_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
                count_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        res_reg  <= res_next;
    end

endmodule

FILE: hdl/nearest_neighbour_tour_unit.sv
// A load is written to the store while the unit stays idle and ready; a build moves
// to the emit state, which registers the start city into the result register.
// Each later tour city comes from a scan of all cities, paced by the single store
// read port and the one shared multiplier used twice per candidate.
// Not ready while a tour is built. Reset (rst_n low, asynchronous) clears the
// sequencer, visited marks and result valid, and sets the city count to 64.
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_unit
// Greedy nearest-neighbour tour builder over a store of loaded cities.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_unit #(
    parameter int MAX_CITIES  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  nnt_pkg::nnt_req_t           req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output nnt_pkg::nnt_res_t           res,
    input  logic                        cfg_we,
    input  logic [nnt_pkg::COUNT_W-1:0] cfg_data
);
    import nnt_pkg::*;

    localparam int IDX_W = $clog2(MAX_CITIES);

    logic                          store_we;
    logic [IDX_W-1:0]              store_waddr;
    logic [IDX_W-1:0]              store_raddr;
    logic signed [COORD_WIDTH-1:0] rx;
    logic signed [COORD_WIDTH-1:0] ry;
    nnt_dist_ctl_t                 dctl;
    logic                          better;

    // Sequencer
    nnt_ctrl #(
        .MAX_CITIES (MAX_CITIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_raddr (store_raddr),
        .dctl        (dctl),
        .better      (better)
    );

    // Coordinate store
    nnt_point_store #(
        .MAX_CITIES  (MAX_CITIES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wx    (req.x_coord),
        .wy    (req.y_coord),
        .raddr (store_raddr),
        .rx    (rx),
        .ry    (ry)
    );

    // Distance and compare
    nnt_dist_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk    (clk),
        .ctl    (dctl),
        .rx     (rx),
        .ry     (ry),
        .better (better)
    );

endmodule

FILE: hdl/nnt_checker.sv
// ----------------------------------------------------------------------------
// nnt_checker
// Port-level checks of the tour unit, bound to the top level.
// ----------------------------------------------------------------------------
module nnt_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  nnt_pkg::nnt_req_t req,
    input  logic              res_valid,
    input  logic              res_ready,
    input  nnt_pkg::nnt_res_t res
);
    import nnt_pkg::*;

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // A new result only appears while a tour is being built
    a_res_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!req_ready))
        else $error("result appeared while idle");

    // A pending result that is not the last means the tour is still running
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last_of_tour |-> !req_ready)
        else $error("ready with tour unfinished");

    // The unit is ready again in the cycle after a load is accepted
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.req_type == REQ_LOAD) |=> req_ready)
        else $error("load did not return to ready");

endmodule

bind nearest_neighbour_tour_unit nnt_checker u_nnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
